### rtl/pmd_pkg.sv
`default_nettype none
package pmd_pkg;
  localparam int PIX_W   = 16;
  localparam int DIFF_W  = PIX_W + 1;
  localparam int K2_W    = 2 * PIX_W;
  localparam int NUM_W   = 3 * PIX_W;
  localparam int DEN_W   = 2 * PIX_W + 1;
  localparam int Q_W     = PIX_W;
  localparam int FLUX_W  = Q_W + 1;
  localparam int SUM_W   = FLUX_W + 2;
  localparam int LANES   = 4;
  localparam int FRONT_STAGES = 2;
  localparam int DIV_STAGES   = Q_W;
  localparam logic [PIX_W-1:0] KAPPA_RESET = 16'd2560;
  localparam logic [PIX_W-1:0] PIX_MAX = '1;

  typedef logic [PIX_W-1:0] pix_t;
  typedef logic [NUM_W-1:0] num_t;
  typedef logic [DEN_W-1:0] den_t;
  typedef logic signed [FLUX_W-1:0] flux_t;
endpackage
`default_nettype wire

### rtl/pmd_if.sv
`default_nettype none
interface pmd_in_if;
  logic valid;
  logic ready;
  pmd_pkg::pix_t center_pixel;
  pmd_pkg::pix_t north_pixel;
  pmd_pkg::pix_t south_pixel;
  pmd_pkg::pix_t west_pixel;
  pmd_pkg::pix_t east_pixel;
  logic at_border;
  modport source(output valid, center_pixel, north_pixel, south_pixel, west_pixel,
                 east_pixel, at_border, input ready);
  modport sink(input valid, center_pixel, north_pixel, south_pixel, west_pixel,
               east_pixel, at_border, output ready);
endinterface

interface pmd_out_if;
  logic valid;
  logic ready;
  pmd_pkg::pix_t new_pixel;
  modport source(output valid, new_pixel, input ready);
  modport sink(input valid, new_pixel, output ready);
endinterface
`default_nettype wire

### rtl/pmd_front.sv
`default_nettype none
module pmd_front (
  input  wire logic clk,
  input  wire logic en,
  input  wire logic [pmd_pkg::K2_W-1:0] k2,
  input  wire pmd_pkg::pix_t mag [pmd_pkg::LANES],
  input  wire logic [pmd_pkg::LANES-1:0] neg,
  output pmd_pkg::num_t num [pmd_pkg::LANES],
  output pmd_pkg::den_t den [pmd_pkg::LANES],
  output logic [pmd_pkg::LANES-1:0] neg_out,
  output logic kz
);
  logic [pmd_pkg::K2_W-1:0] sq [pmd_pkg::LANES];
  pmd_pkg::num_t num_a [pmd_pkg::LANES];
  logic [pmd_pkg::K2_W-1:0] k2_a;
  logic [pmd_pkg::LANES-1:0] neg_a;

  // stage a: products, stage b: denominator
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < pmd_pkg::LANES; i++) begin
        sq[i]    <= pmd_pkg::K2_W'(mag[i]) * pmd_pkg::K2_W'(mag[i]);
        num_a[i] <= pmd_pkg::NUM_W'(mag[i]) * pmd_pkg::NUM_W'(k2);
      end
      k2_a  <= k2;
      neg_a <= neg;
      for (int i = 0; i < pmd_pkg::LANES; i++) begin
        den[i] <= pmd_pkg::DEN_W'(sq[i]) + pmd_pkg::DEN_W'(k2_a);
        num[i] <= num_a[i];
      end
      neg_out <= neg_a;
      kz      <= (k2_a == '0);
    end
  end
endmodule
`default_nettype wire

### rtl/pmd_div_lane.sv
`default_nettype none
module pmd_div_lane (
  input  wire logic clk,
  input  wire logic en,
  input  wire pmd_pkg::num_t num,
  input  wire pmd_pkg::den_t den,
  input  wire logic neg,
  input  wire logic kz,
  output pmd_pkg::flux_t flux
);
  localparam int N = pmd_pkg::DIV_STAGES;
  localparam int RW = pmd_pkg::DEN_W;

  logic [RW-1:0]          rem [N+1];
  logic [pmd_pkg::Q_W-1:0] lo [N+1];
  logic [pmd_pkg::Q_W-1:0] quo [N+1];
  pmd_pkg::den_t          dv [N+1];
  logic                   ng [N+1];
  logic                   zr [N+1];

  // quotient fits in Q_W bits, so the high part starts below the divisor
  assign rem[0] = RW'(num[pmd_pkg::NUM_W-1:pmd_pkg::Q_W]);
  assign lo[0]  = num[pmd_pkg::Q_W-1:0];
  assign quo[0] = '0;
  assign dv[0]  = den;
  assign ng[0]  = neg;
  assign zr[0]  = kz;

  for (genvar s = 0; s < N; s++) begin : g_step
    logic [RW:0] t;
    logic        ge;
    assign t  = {rem[s], lo[s][pmd_pkg::Q_W-1]};
    assign ge = (t >= {1'b0, dv[s]});
    always_ff @(posedge clk) begin
      if (en) begin
        rem[s+1] <= ge ? RW'(t - {1'b0, dv[s]}) : t[RW-1:0];
        lo[s+1]  <= {lo[s][pmd_pkg::Q_W-2:0], 1'b0};
        quo[s+1] <= {quo[s][pmd_pkg::Q_W-2:0], ge};
        dv[s+1]  <= dv[s];
        ng[s+1]  <= ng[s];
        zr[s+1]  <= zr[s];
      end
    end
  end

  always_comb begin
    if (zr[N]) flux = '0;
    else if (ng[N]) flux = -$signed({1'b0, quo[N]});
    else flux = $signed({1'b0, quo[N]});
  end
endmodule
`default_nettype wire

### rtl/perona_malik_diffusion_cell_unit.sv
// Perona-Malik diffusion cell: one explicit diffusion update per pixel window.
// px_in carries the center pixel, its four neighbours and a border flag; a
// request is taken when valid and ready are both high. px_out returns one
// new_pixel per request, in order. The user must write kappa through
// kappa_wr_en and kappa_wr_data only while no request is in flight; the block
// does not enforce this. Its square is registered and feeds the flux products.
// From input request to output valid the pipe runs through an input register,
// two product/denominator stages, 16 restoring divider stages (one quotient
// bit each, four lanes), a flux sum stage and an output saturation register.
// It takes one pixel per cycle unless stalled; the divider chain sets the depth.
// When the receiver holds ready low with a result waiting, the whole pipe
// freezes and px_in.ready drops, so nothing is lost or repeated.
// Reset clears all valid bits and loads kappa with 2560 (KAPPA_RESET).
`default_nettype none
module perona_malik_diffusion_cell_unit (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic kappa_wr_en,
  input  wire pmd_pkg::pix_t kappa_wr_data,
  pmd_in_if.sink    px_in,
  pmd_out_if.source px_out
);
  localparam int DEPTH = 1 + pmd_pkg::FRONT_STAGES + pmd_pkg::DIV_STAGES + 2;
  localparam int CDEP  = DEPTH - 1;

  pmd_pkg::pix_t kappa;
  logic [pmd_pkg::K2_W-1:0] k2;
  logic [DEPTH-1:0] vld;
  logic en;

  pmd_pkg::pix_t c_pipe [CDEP];
  logic          b_pipe [CDEP];
  pmd_pkg::pix_t nb [pmd_pkg::LANES];
  pmd_pkg::pix_t mag [pmd_pkg::LANES];
  logic [pmd_pkg::LANES-1:0] neg;
  pmd_pkg::num_t num [pmd_pkg::LANES];
  pmd_pkg::den_t den [pmd_pkg::LANES];
  logic [pmd_pkg::LANES-1:0] neg_f;
  logic kz;
  pmd_pkg::flux_t flux [pmd_pkg::LANES];
  logic signed [pmd_pkg::SUM_W-1:0] sum;
  logic signed [pmd_pkg::SUM_W-1:0] step;
  logic signed [pmd_pkg::SUM_W-1:0] step_q;
  logic signed [pmd_pkg::SUM_W:0] v;
  pmd_pkg::pix_t res;

  assign en = !vld[DEPTH-1] || px_out.ready;
  assign px_in.ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      kappa <= pmd_pkg::KAPPA_RESET;
    end else if (kappa_wr_en) begin
      kappa <= kappa_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    k2 <= kappa * kappa;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[DEPTH-2:0], px_in.valid};
    end
  end

  // input stage
  always_ff @(posedge clk) begin
    if (en) begin
      c_pipe[0] <= px_in.center_pixel;
      b_pipe[0] <= px_in.at_border;
      nb[0] <= px_in.north_pixel;
      nb[1] <= px_in.south_pixel;
      nb[2] <= px_in.west_pixel;
      nb[3] <= px_in.east_pixel;
      for (int i = 1; i < CDEP; i++) begin
        c_pipe[i] <= c_pipe[i-1];
        b_pipe[i] <= b_pipe[i-1];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < pmd_pkg::LANES; i++) begin
      neg[i] = nb[i] < c_pipe[0];
      mag[i] = neg[i] ? c_pipe[0] - nb[i] : nb[i] - c_pipe[0];
    end
  end

  pmd_front u_front (
    .clk(clk), .en(en), .k2(k2), .mag(mag), .neg(neg),
    .num(num), .den(den), .neg_out(neg_f), .kz(kz)
  );

  for (genvar l = 0; l < pmd_pkg::LANES; l++) begin : g_lane
    pmd_div_lane u_div (
      .clk(clk), .en(en), .num(num[l]), .den(den[l]),
      .neg(neg_f[l]), .kz(kz), .flux(flux[l])
    );
  end

  always_comb begin
    sum = '0;
    for (int i = 0; i < pmd_pkg::LANES; i++) begin
      sum = sum + pmd_pkg::SUM_W'(flux[i]);
    end
    // divide by four, rounding toward zero
    step = sum[pmd_pkg::SUM_W-1] ? (sum + pmd_pkg::SUM_W'(3)) >>> 2 : sum >>> 2;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      step_q <= step;
    end
  end

  assign v = $signed({2'b00, c_pipe[CDEP-1]}) + (pmd_pkg::SUM_W+1)'(step_q);

  always_comb begin
    if (b_pipe[CDEP-1]) res = c_pipe[CDEP-1];
    else if (v < 0) res = '0;
    else if (v > $signed({2'b00, pmd_pkg::PIX_MAX})) res = pmd_pkg::PIX_MAX;
    else res = v[pmd_pkg::PIX_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      px_out.new_pixel <= res;
    end
  end

  assign px_out.valid = vld[DEPTH-1];

  a_ready: assert property (@(posedge clk) disable iff (rst)
    px_in.ready == (!px_out.valid || px_out.ready))
    else $error("input ready does not follow output stall");

  a_rst: assert property (@(posedge clk) rst |=> !px_out.valid)
    else $error("result valid right after reset");

  a_border: assert property (@(posedge clk) disable iff (rst)
    (en && vld[DEPTH-2] && b_pipe[CDEP-1]) |=> px_out.new_pixel == $past(c_pipe[CDEP-1]))
    else $error("border pixel not passed through");
endmodule
`default_nettype wire

### dv/tb_top.sv
`default_nettype none
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  typedef pmd_pkg::pix_t pix_t;

  typedef struct packed {
    pix_t c;
    pix_t n;
    pix_t s;
    pix_t w;
    pix_t e;
    logic border;
  } window_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic kappa_wr_en = 1'b0;
  pix_t kappa_wr_data = '0;

  pmd_in_if px_in();
  pmd_out_if px_out();

  perona_malik_diffusion_cell_unit dut (
    .clk(clk),
    .rst(rst),
    .kappa_wr_en(kappa_wr_en),
    .kappa_wr_data(kappa_wr_data),
    .px_in(px_in.sink),
    .px_out(px_out.source)
  );

  always #1 clk = ~clk;

  window_t pending_windows[$];
  pix_t expected_pixels[$];
  pix_t kappa_model;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int error_count = 0;
  int sent_count = 0;
  int checked_count = 0;
  int border_count = 0;
  int sat_count = 0;
  longint cycle_count = 0;
  logic in_fire = 1'b0;

  // flux d*K^2/(K^2+d^2), quotient truncated toward zero
  function automatic longint pm_flux(longint d, longint k);
    longint mag;
    longint k2;
    longint q;
    mag = (d < 0) ? -d : d;
    k2 = k * k;
    if (k2 == 0) return 0;
    q = (mag * k2) / (k2 + mag * mag);
    return (d < 0) ? -q : q;
  endfunction

  function automatic pix_t diffuse(window_t win, pix_t k);
    longint c;
    longint sum;
    longint v;
    c = win.c;
    if (win.border) return win.c;
    sum = pm_flux(longint'(win.n) - c, k) + pm_flux(longint'(win.s) - c, k) +
          pm_flux(longint'(win.w) - c, k) + pm_flux(longint'(win.e) - c, k);
    v = c + sum / 4;  // longint division truncates toward zero
    if (v < 0) v = 0;
    if (v > 65535) v = 65535;
    return pix_t'(v);
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
    error_count++;
  endtask

  // driver
  always @(negedge clk) begin
    if (rst) begin
      px_in.valid <= 1'b0;
    end else if (!px_in.valid || in_fire) begin
      if (pending_windows.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        window_t w;
        w = pending_windows.pop_front();
        px_in.valid <= 1'b1;
        {px_in.center_pixel, px_in.north_pixel, px_in.south_pixel,
         px_in.west_pixel, px_in.east_pixel, px_in.at_border} <= w;
      end else begin
        px_in.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    px_out.ready <= rst ? 1'b0 : ($urandom_range(99) >= recv_stall_pct);
  end

  // monitor: requests accepted at the rising edge, results checked in order
  always @(posedge clk) begin
    cycle_count++;
    in_fire = !rst && px_in.valid && px_in.ready;
    if (in_fire) begin
      window_t w;
      w = {px_in.center_pixel, px_in.north_pixel, px_in.south_pixel,
           px_in.west_pixel, px_in.east_pixel, px_in.at_border};
      expected_pixels.push_back(diffuse(w, kappa_model));
      sent_count++;
      if (w.border) border_count++;
    end
    if (!rst && px_out.valid && px_out.ready) begin
      if (expected_pixels.size() == 0) begin
        report_mismatch($sformatf("unexpected new_pixel %h", px_out.new_pixel));
      end else begin
        pix_t exp_px;
        exp_px = expected_pixels.pop_front();
        if (exp_px == 16'hffff || exp_px == 16'h0000) sat_count++;
        if (px_out.new_pixel !== exp_px)
          report_mismatch($sformatf("new_pixel %h expected %h", px_out.new_pixel, exp_px));
      end
      checked_count++;
    end
    if (cycle_count > 400000) begin
      $display("timeout with %0d results outstanding", expected_pixels.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic pix_t rand_pix();
    case ($urandom_range(3))
      0: return pix_t'($urandom);
      1: return pix_t'($urandom_range(3)) ? 16'hffff - pix_t'($urandom_range(15)) : 16'hffff;
      default: return pix_t'($urandom_range(15));
    endcase
  endfunction

  function automatic window_t rand_window();
    window_t w;
    pix_t base;
    int spread;
    base = pix_t'($urandom);
    spread = 1 << $urandom_range(16);
    w.c = ($urandom_range(7) == 0) ? rand_pix() : base;
    w.n = pix_t'(base + $urandom_range(spread) - spread / 2);
    w.s = pix_t'(base + $urandom_range(spread) - spread / 2);
    w.w = pix_t'(base + $urandom_range(spread) - spread / 2);
    w.e = pix_t'(base + $urandom_range(spread) - spread / 2);
    if ($urandom_range(9) == 0) w.n = rand_pix();
    if ($urandom_range(9) == 0) w.e = rand_pix();
    w.border = ($urandom_range(9) == 0);
    return w;
  endfunction

  task automatic drain();
    while (pending_windows.size() > 0 || expected_pixels.size() > 0 || px_in.valid)
      @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic write_kappa(input pix_t k);
    @(negedge clk);
    kappa_wr_en <= 1'b1;
    kappa_wr_data <= k;
    @(negedge clk);
    kappa_wr_en <= 1'b0;
    kappa_model = k;
  endtask

  initial begin
    pix_t kappas[6];
    int idle_s[4];
    int idle_r[4];
    kappas = '{16'd2560, 16'd1, 16'hffff, 16'd0, 16'd256, 16'd40};
    idle_s = '{0, 60, 0, 8};
    idle_r = '{0, 0, 60, 8};
    kappa_model = pmd_pkg::KAPPA_RESET;
    px_in.valid = 1'b0;
    px_in.center_pixel = '0;
    px_in.north_pixel = '0;
    px_in.south_pixel = '0;
    px_in.west_pixel = '0;
    px_in.east_pixel = '0;
    px_in.at_border = 1'b0;
    px_out.ready = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: extremes, border, flat, steep edges, near both ends of the range
    pending_windows.push_back('{16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0});
    pending_windows.push_back('{16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 1'b0});
    pending_windows.push_back('{16'h0000, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 1'b0});
    pending_windows.push_back('{16'hffff, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0});
    pending_windows.push_back('{16'h0000, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 1'b1});
    pending_windows.push_back('{16'h1000, 16'h1a00, 16'h0600, 16'h1000, 16'h1a00, 1'b0});
    pending_windows.push_back('{16'hfff0, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 1'b0});
    pending_windows.push_back('{16'h0005, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0});
    pending_windows.push_back('{16'h8000, 16'h8a00, 16'h7600, 16'h8500, 16'h7b00, 1'b0});
    pending_windows.push_back('{16'h5555, 16'haaaa, 16'h5555, 16'haaaa, 16'h5555, 1'b1});
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      if (ph > 0) write_kappa(kappas[ph]);
      for (int ip = 0; ip < 4; ip++) begin
        send_idle_pct = idle_s[ip];
        recv_stall_pct = idle_r[ip];
        for (int i = 0; i < 30; i++) pending_windows.push_back(rand_window());
        if (ph == 0) pending_windows.push_back('{16'hffff, 16'h0000, 16'hffff,
                                                   16'h0000, 16'hffff, 1'b0});
        drain();
      end
    end
    write_kappa(pix_t'($urandom));
    for (int i = 0; i < 40; i++) pending_windows.push_back(rand_window());
    drain();

    $display("%0d pixel windows checked over 7 kappa settings, %0d border, %0d saturated",
             checked_count, border_count, sat_count);
    $display("idle phases: none, sender 60%%, receiver 60%%, both 8%%");
    if (error_count == 0 && expected_pixels.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
`default_nettype wire

### filelist.f
rtl/pmd_pkg.sv
rtl/pmd_if.sv
rtl/pmd_front.sv
rtl/pmd_div_lane.sv
rtl/perona_malik_diffusion_cell_unit.sv
dv/tb_top.sv
